FILE: hw/rtl/fatc_pkg.sv
// Shared types and constants for the file access tier classifier.
package fatc_pkg;

    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 32;
    localparam int TICK_W   = 64;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 9;
    localparam int SWEEP_W  = 10;
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 32;

    localparam logic [OPCODE_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ACCESS   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_OPTIMIZE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [1:0] TIER_HOT  = 2'd0;
    localparam logic [1:0] TIER_WARM = 2'd1;
    localparam logic [1:0] TIER_COLD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HOT_COUNT_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_COUNT_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_AGE_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_AGE_LIMIT = 2'd3;

    localparam logic [CFG_W-1:0] RST_HOT_COUNT_MIN  = 32'd10;
    localparam logic [CFG_W-1:0] RST_COLD_COUNT_MAX = 32'd2;
    localparam logic [CFG_W-1:0] RST_HOT_AGE_LIMIT  = 32'd1000;
    localparam logic [CFG_W-1:0] RST_COLD_AGE_LIMIT = 32'd100000;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [31:0]       count;
        logic [TICK_W-1:0] tick;
        logic [1:0]        tier;
        logic              comp;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic start;
        logic step;
        logic out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
    } dp_stat_t;

endpackage

FILE: hw/rtl/fatc_ctrl.sv
// Sequencer for the classifier: accept, scan, deliver.
module fatc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output fatc_pkg::dp_cmd_t cmd,
    input  fatc_pkg::dp_stat_t stat
);
    import fatc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_vld_reg, out_vld_next;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_vld_reg;
    assign out_free = !out_vld_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    cmd.start   = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                    state_next = S_FIN;
                else
                    cmd.step = 1'b1;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

`ifndef ASSERT_OFF
    // a result is only loaded into a free output slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_vld_reg || m_tready))
        else $error("result loaded over a pending beat");
    // every scan is followed by a delivery state before the next accept
    a_scan_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && stat.scan_done) |=> (state_reg == S_FIN))
        else $error("scan did not finish into delivery");
    // no new beat taken while a scan runs
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !s_tready)
        else $error("input accepted during scan");
`endif

endmodule

FILE: hw/rtl/fatc_dp.sv
// Datapath: entry memory, config registers, scan pointer, sweep counters.
module fatc_dp #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fatc_pkg::dp_cmd_t                 cmd,
    output fatc_pkg::dp_stat_t                stat,
    input  logic [fatc_pkg::OPCODE_W-1:0]     in_opcode,
    input  logic [fatc_pkg::KEY_W-1:0]        in_file_key,
    input  logic [fatc_pkg::TICK_W-1:0]       in_now_tick,
    input  logic                              cfg_we,
    input  logic [fatc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fatc_pkg::CFG_W-1:0]        cfg_data,
    output logic [fatc_pkg::STATUS_W-1:0]     status,
    output logic [fatc_pkg::INDEX_W-1:0]      entry_index,
    output logic [fatc_pkg::SWEEP_W-1:0]      newly_hot,
    output logic [fatc_pkg::SWEEP_W-1:0]      newly_compressed
);
    import fatc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    entry_t mem [TABLE_DEPTH];

    logic [CFG_W-1:0] hot_min_reg, cold_max_reg, hot_lim_reg, cold_lim_reg;

    logic [OPCODE_W-1:0] op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [TICK_W-1:0]   tick_reg;

    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg;
    entry_t           rd_data_reg;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] found_idx_reg, found_idx_next;
    logic [CNT_W-1:0] hot_cnt_reg, hot_cnt_next;
    logic [CNT_W-1:0] comp_cnt_reg, comp_cnt_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic [SWEEP_W-1:0]  hot_out_reg, hot_out_next;
    logic [SWEEP_W-1:0]  comp_out_reg, comp_out_next;

    logic             is_access, is_sweep, is_full;
    logic             hit;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    entry_t           upd;
    logic [TICK_W-1:0] age;
    logic             hot_ok, cold_ok;

    assign is_access = (op_reg == OP_ACCESS);
    assign is_sweep  = (op_reg == OP_OPTIMIZE);
    assign is_full   = (total_reg == DEPTH_C);
    assign hit       = rd_vld_reg && is_access && (rd_data_reg.key == key_reg);

    assign age     = tick_reg - rd_data_reg.tick;
    assign hot_ok  = (rd_data_reg.count >= hot_min_reg) &&
                     (age < {{(TICK_W-CFG_W){1'b0}}, hot_lim_reg});
    assign cold_ok = (rd_data_reg.count <= cold_max_reg) ||
                     (age > {{(TICK_W-CFG_W){1'b0}}, cold_lim_reg});

    assign stat.scan_done = !(is_access || is_sweep) || found_reg ||
                            ((ptr_reg == total_reg) && !rd_vld_reg);

    // tier update for the entry now at the read register
    always_comb
    begin
        upd           = rd_data_reg;
        hot_cnt_next  = hot_cnt_reg;
        comp_cnt_next = comp_cnt_reg;
        if (hot_ok)
        begin
            if (rd_data_reg.tier != TIER_HOT)
            begin
                upd.tier     = TIER_HOT;
                upd.comp     = 1'b0;
                hot_cnt_next = hot_cnt_reg + 1'b1;
            end
        end
        else if (cold_ok)
        begin
            if (rd_data_reg.tier != TIER_COLD)
            begin
                upd.tier = TIER_COLD;
                if (!rd_data_reg.comp)
                begin
                    upd.comp      = 1'b1;
                    comp_cnt_next = comp_cnt_reg + 1'b1;
                end
            end
        end
        else
        begin
            upd.tier = TIER_WARM;
        end
        if (cmd.start || !(cmd.step && rd_vld_reg && is_sweep))
        begin
            hot_cnt_next  = cmd.start ? '0 : hot_cnt_reg;
            comp_cnt_next = cmd.start ? '0 : comp_cnt_reg;
        end
    end

    // scan pointer, read issue, memory write selection
    always_comb
    begin
        ptr_next       = ptr_reg;
        rd_vld_next    = 1'b0;
        rd_en          = 1'b0;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        total_next     = total_reg;
        wr_en          = 1'b0;
        wr_addr        = rd_idx_reg;
        wr_data        = upd;
        if (cmd.start)
        begin
            ptr_next   = '0;
            found_next = 1'b0;
        end
        else if (cmd.step)
        begin
            if ((ptr_reg != total_reg) && !hit && !found_reg)
            begin
                rd_en       = 1'b1;
                rd_vld_next = 1'b1;
                ptr_next    = ptr_reg + 1'b1;
            end
            if (hit)
            begin
                found_next       = 1'b1;
                found_idx_next   = rd_idx_reg;
                wr_en            = 1'b1;
                wr_data          = rd_data_reg;
                wr_data.tick     = tick_reg;
                if (rd_data_reg.count != COUNT_MAX)
                    wr_data.count = rd_data_reg.count + 1'b1;
            end
            else if (rd_vld_reg && is_sweep)
            begin
                wr_en = 1'b1;
            end
        end
        else if (cmd.out_load && (op_reg == OP_REGISTER) && !is_full)
        begin
            wr_en        = 1'b1;
            wr_addr      = total_reg[IDX_W-1:0];
            wr_data.key  = key_reg;
            wr_data.count = '0;
            wr_data.tick = '0;
            wr_data.tier = TIER_WARM;
            wr_data.comp = 1'b0;
            total_next   = total_reg + 1'b1;
        end
    end

    // result beat
    always_comb
    begin
        status_next   = ST_OK;
        index_next    = '0;
        hot_out_next  = '0;
        comp_out_next = '0;
        case (op_reg)
            OP_REGISTER:
            begin
                if (is_full)
                    status_next = ST_FULL;
                else
                    index_next = INDEX_W'(total_reg);
            end
            OP_ACCESS:
            begin
                if (found_reg)
                    index_next = INDEX_W'(found_idx_reg);
                else
                    status_next = ST_NOT_FOUND;
            end
            OP_OPTIMIZE:
            begin
                hot_out_next  = SWEEP_W'(hot_cnt_reg);
                comp_out_next = SWEEP_W'(comp_cnt_reg);
            end
            default: status_next = ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
            rd_idx_reg  <= ptr_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_opcode;
            key_reg  <= in_file_key;
            tick_reg <= in_now_tick;
        end
        if (cmd.out_load)
        begin
            status_reg   <= status_next;
            index_reg    <= index_next;
            hot_out_reg  <= hot_out_next;
            comp_out_reg <= comp_out_next;
        end
        found_idx_reg <= found_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hot_min_reg  <= RST_HOT_COUNT_MIN;
            cold_max_reg <= RST_COLD_COUNT_MAX;
            hot_lim_reg  <= RST_HOT_AGE_LIMIT;
            cold_lim_reg <= RST_COLD_AGE_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOT_COUNT_MIN:  hot_min_reg  <= cfg_data;
                CFG_COLD_COUNT_MAX: cold_max_reg <= cfg_data;
                CFG_HOT_AGE_LIMIT:  hot_lim_reg  <= cfg_data;
                CFG_COLD_AGE_LIMIT: cold_lim_reg <= cfg_data;
                default:            hot_min_reg  <= hot_min_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            ptr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            hot_cnt_reg  <= '0;
            comp_cnt_reg <= '0;
        end
        else
        begin
            total_reg    <= total_next;
            ptr_reg      <= ptr_next;
            rd_vld_reg   <= rd_vld_next;
            found_reg    <= found_next;
            hot_cnt_reg  <= hot_cnt_next;
            comp_cnt_reg <= comp_cnt_next;
        end
    end

    assign status           = status_reg;
    assign entry_index      = index_reg;
    assign newly_hot        = hot_out_reg;
    assign newly_compressed = comp_out_reg;

`ifndef ASSERT_OFF
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= DEPTH_C)
        else $error("entry total beyond table depth");
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (CNT_W'(rd_idx_reg) < total_reg))
        else $error("scan read past last entry");
    a_found_access: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> is_access)
        else $error("match flag set outside an access");
    a_no_read_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> !rd_vld_reg)
        else $error("read issued after a match");
`endif

endmodule

FILE: hw/rtl/file_access_tier_classifier_unit.sv
// Top level of the file access tier classifier: stream ports and unit wiring.
// One beat is worked at a time. Register and unused opcodes pass from acceptance through
// the scan state to delivery without a table read; access and optimize walk the table
// through the single read port of the entry memory, one entry per cycle, and an access
// stops at the first matching key. The input is ready again as soon as the result sits
// in the output register. Tables need no clearing pass after reset. Config writes are
// always taken and must arrive only while idle.
module file_access_tier_classifier_unit #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // opcode[1:0], file_key[33:2], now_tick[97:34], zero pad
    input  logic [fatc_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], entry_index[10:2], newly_hot[20:11], newly_compressed[30:21], zero pad
    output logic [fatc_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fatc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fatc_pkg::CFG_W-1:0]        cfg_data
);
    import fatc_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  entry_index;
    logic [SWEEP_W-1:0]  newly_hot;
    logic [SWEEP_W-1:0]  newly_compressed;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {1'b0, newly_compressed, newly_hot, entry_index, status};

    fatc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    fatc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_opcode        (s_tdata[1:0]),
        .in_file_key      (s_tdata[33:2]),
        .in_now_tick      (s_tdata[97:34]),
        .cfg_we           (cfg_valid & cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .status           (status),
        .entry_index      (entry_index),
        .newly_hot        (newly_hot),
        .newly_compressed (newly_compressed)
    );

endmodule
